@@ rtl/zpc_pkg.sv @@
// Shared types, constants and sizes for the zero padded kernel convolution.
`default_nettype none
package zpc_pkg;
    localparam int KDIM        = 5;
    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int LAG         = KDIM - 1 - KDIM / 2;
    localparam int TAPS        = KDIM * KDIM;
    localparam int LANES       = KDIM - 1;
    localparam int DIM_W       = 11;
    localparam int COL_AW      = $clog2(MAX_COLS);
    localparam int PIX_W       = 8;
    localparam int COEF_W      = 16;
    localparam int IDX_W       = 5;
    localparam int PROD_W      = PIX_W + COEF_W;
    localparam int ROW_W       = PROD_W + $clog2(KDIM);
    localparam int ACC_W       = PROD_W + $clog2(TAPS);
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [7:0] REG_IMAGE_ROWS = 8'd0;
    localparam logic [7:0] REG_IMAGE_COLS = 8'd1;

    typedef struct packed {
        logic                  is_load;
        logic [IDX_W-1:0]      coef_idx;
        logic [COEF_W-1:0]     coef_val;
        logic [PIX_W-1:0]      pix;
        logic [COL_AW-1:0]     addr;
        logic                  in_col;
        logic                  clr;
        logic [LANES-1:0]      mask;
        logic                  emit;
        logic                  eol;
        logic                  eof;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage
`default_nettype wire

@@ rtl/zero_padded_kernel_convolution.sv @@
// Top level: 5x5 zero padded convolution over a raster pixel stream.
//  channel | direction | beat contents
//  s_axis  | in        | tdata {coef_value, coef_index, pixel_value}, tuser mode
//  m_axis  | out       | tdata blurred_pixel, tuser end_of_line, tlast end_of_frame
//  cfg     | in        | index 0 image_rows, 1 image_cols, data 11 bits
// One item per clock sustained while the output is not stalled.
// The rate is set by the single line buffer port pair: one column read and written per beat.
// Reset is synchronous; no clearing pass, line buffer rows are masked until filled.
// Output stalls freeze the back end while the four entry queue keeps taking input until full.
`default_nettype none
module zero_padded_kernel_convolution
    import zpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [7:0] pixel_value, [12:8] coef_index, [28:13] coef_value
    input  wire logic [0:0]  s_axis_tuser,  // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] blurred_pixel
    output logic [0:0]       m_axis_tuser,  // [0] end_of_line
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);
    t_item   f_item, q_head;
    t_q_stat q_stat;
    logic    f_push, b_pop;

    assign s_axis_tready = !q_stat.full;
    assign o_cfg_ready   = 1'b1;

    zpc_front u_front (
        .i_clk, .i_rst_n,
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (s_axis_tvalid && s_axis_tready),
        .i_mode      (s_axis_tuser[0]),
        .i_pix       (s_axis_tdata[7:0]),
        .i_idx       (s_axis_tdata[12:8]),
        .i_coef      (s_axis_tdata[28:13]),
        .o_item      (f_item),
        .o_push      (f_push)
    );

    zpc_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push (f_push),
        .i_item (f_item),
        .i_pop  (b_pop),
        .o_head (q_head),
        .o_stat (q_stat)
    );

    zpc_back u_back (
        .i_clk, .i_rst_n,
        .i_head  (q_head),
        .i_empty (q_stat.empty),
        .o_pop   (b_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pix   (m_axis_tdata),
        .o_eol   (m_axis_tuser[0]),
        .o_eof   (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_eof_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0]) else $error("frame end off line end");
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty)) else $error("queue full and empty");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !b_pop) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

@@ rtl/zpc_front.sv @@
// Front end: raster position tracking, size registers and item classification.
`default_nettype none
module zpc_front
    import zpc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [7:0]        i_cfg_index,
    input  wire logic [DIM_W-1:0]  i_cfg_data,
    input  wire logic              i_accept,
    input  wire logic              i_mode,
    input  wire logic [PIX_W-1:0]  i_pix,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire logic [COEF_W-1:0] i_coef,
    output t_item                  o_item,
    output logic                   o_push
);
    logic [DIM_W-1:0] r_rows, r_cols, n_rows, n_cols;
    logic [DIM_W-1:0] r_pr, r_pc, n_pr, n_pc;
    logic             pix_step;

    function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] v, input int mx);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_W'(mx)) r = DIM_W'(mx);
        return r;
    endfunction

    assign pix_step = i_accept && !i_mode;

    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        n_pr   = r_pr;
        n_pc   = r_pc;
        if (i_cfg_valid && (i_cfg_index == REG_IMAGE_ROWS || i_cfg_index == REG_IMAGE_COLS)) begin
            if (i_cfg_index == REG_IMAGE_ROWS) n_rows = eff(i_cfg_data, MAX_ROWS);
            else n_cols = eff(i_cfg_data, MAX_COLS);
            n_pr = '0;
            n_pc = '0;
        end else if (pix_step) begin
            if (r_pc + DIM_W'(1) >= r_cols + DIM_W'(LAG)) begin
                n_pc = '0;
                n_pr = (r_pr + DIM_W'(1) >= r_rows + DIM_W'(LAG)) ? '0 : r_pr + DIM_W'(1);
            end else begin
                n_pc = r_pc + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_W'(MAX_ROWS);
            r_cols <= DIM_W'(MAX_COLS);
            r_pr   <= '0;
            r_pc   <= '0;
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
            r_pr   <= n_pr;
            r_pc   <= n_pc;
        end
    end

    always_comb begin
        o_item.is_load  = i_mode;
        o_item.coef_idx = i_idx;
        o_item.coef_val = i_coef;
        o_item.in_col   = r_pc < r_cols;
        o_item.pix      = (r_pr < r_rows && o_item.in_col) ? i_pix : '0;
        o_item.addr     = r_pc[COL_AW-1:0];
        o_item.clr      = r_pc == '0;
        for (int i = 0; i < LANES; i++) begin
            o_item.mask[i] = (r_pr + DIM_W'(i)) < DIM_W'(LANES);
        end
        o_item.emit = r_pr >= DIM_W'(LAG) && r_pc >= DIM_W'(LAG)
                      && (r_pr - DIM_W'(LAG)) < r_rows && (r_pc - DIM_W'(LAG)) < r_cols;
        o_item.eol  = r_pc == r_cols + DIM_W'(LAG - 1);
        o_item.eof  = o_item.eol && r_pr == r_rows + DIM_W'(LAG - 1);
        // drop loads to a position outside the kernel
        o_push = i_accept && (!i_mode || i_idx < IDX_W'(TAPS));
    end
endmodule
`default_nettype wire

@@ rtl/zpc_fifo.sv @@
// Short item queue between the front end and the convolution back end.
`default_nettype none
module zpc_fifo
    import zpc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_head,
    output t_q_stat    o_stat
);
    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_AW'(1);
            if (i_pop)  r_rp <= r_rp + Q_AW'(1);
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/zpc_back.sv @@
// Back end: line buffers, window, coefficients, multiply and adder tree, output register.
`default_nettype none
module zpc_back
    import zpc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_item            i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [PIX_W-1:0]      o_pix,
    output logic                  o_eol,
    output logic                  o_eof
);
    logic [LANES*PIX_W-1:0] r_lb [MAX_COLS];
    logic [LANES*PIX_W-1:0] r_rd, wdata;
    logic [PIX_W-1:0]  r_win [KDIM][KDIM];
    logic [PIX_W-1:0]  n_win [KDIM][KDIM];
    logic [COEF_W-1:0] r_coef [TAPS];
    logic [PROD_W-1:0] r_prod [TAPS];
    logic [ROW_W-1:0]  r_row [KDIM];
    logic [ROW_W-1:0]  n_row [KDIM];
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-16:0] rnd;
    t_item r_a;
    logic  r_a_v, r_b_v, r_b_eol, r_b_eof, r_c_v, r_c_eol, r_c_eof;
    logic  r_d_v, r_d_eol, r_d_eof;
    logic  en;

    assign en    = !o_valid || i_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        for (int i = 0; i < KDIM; i++) begin
            for (int j = 0; j < KDIM - 1; j++) begin
                n_win[i][j] = r_a.clr ? '0 : r_win[i][j+1];
            end
            if (i < LANES) begin
                n_win[i][KDIM-1] = (r_a.in_col && !r_a.mask[i])
                                   ? r_rd[i*PIX_W +: PIX_W] : '0;
            end else begin
                n_win[i][KDIM-1] = r_a.in_col ? r_a.pix : '0;
            end
        end
        for (int i = 0; i < LANES - 1; i++) begin
            wdata[i*PIX_W +: PIX_W] = r_rd[(i+1)*PIX_W +: PIX_W];
        end
        wdata[(LANES-1)*PIX_W +: PIX_W] = r_a.pix;
    end

    // line buffer read for the item entering, update for the item in hand
    always_ff @(posedge i_clk) begin
        if (o_pop) r_rd <= r_lb[i_head.addr];
        if (en && r_a_v && !r_a.is_load && r_a.in_col) r_lb[r_a.addr] <= wdata;
    end

    always_comb begin
        for (int i = 0; i < KDIM; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < KDIM; j++) begin
                n_row[i] = n_row[i] + ROW_W'(r_prod[i*KDIM+j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_a <= i_head;
        if (en && r_a_v && !r_a.is_load) r_win <= n_win;
        if (en) begin
            for (int t = 0; t < TAPS; t++) begin
                r_prod[t] <= PROD_W'(r_win[t / KDIM][t % KDIM] * r_coef[t]);
            end
            r_row   <= n_row;
            r_b_eol <= r_a.eol; r_b_eof <= r_a.eof;
            r_c_eol <= r_b_eol; r_c_eof <= r_b_eof;
            r_d_eol <= r_c_eol; r_d_eof <= r_c_eof;
            o_eol   <= r_d_eol; o_eof   <= r_d_eof;
            o_pix   <= (rnd > (ACC_W-15)'(255)) ? PIX_W'(255) : rnd[PIX_W-1:0];
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < KDIM; i++) acc = acc + ACC_W'(r_row[i]);
        rnd = (ACC_W-15)'((acc + ACC_W'(16'h8000)) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0; r_b_v <= 1'b0; r_c_v <= 1'b0; r_d_v <= 1'b0; o_valid <= 1'b0;
            for (int t = 0; t < TAPS; t++) r_coef[t] <= '0;
        end else if (en) begin
            r_a_v   <= !i_empty;
            r_b_v   <= r_a_v && !r_a.is_load && r_a.emit;
            r_c_v   <= r_b_v;
            r_d_v   <= r_c_v;
            o_valid <= r_d_v;
            if (r_a_v && r_a.is_load) r_coef[r_a.coef_idx] <= r_a.coef_val;
        end
    end
endmodule
`default_nettype wire
